>>> rtl/esw_pkg.sv
// ----------------------------------------------------------------------------
// esw_pkg: shared types and constants of the event sensor word decoder
// Word header codes, the time scale of reference words and the job record
// that passes from the decoder to the event expander.
// ----------------------------------------------------------------------------
`default_nettype none

package esw_pkg;

   // Header field of a non-group word is b0 masked with this.
   localparam logic [7:0] HDR_MASK   = 8'h7C;
   localparam logic [7:0] HDR_COLUMN = 8'h04;
   localparam logic [7:0] HDR_REF    = 8'h08;

   // A reference word carries the long time in units of 1000 microseconds.
   localparam logic [9:0] REF_SCALE = 10'd1000;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   // Work left for one accepted word: up to 16 pixel events or one error.
   typedef struct packed {
      logic [15:0] mask;      // upper byte is the upper row group
      logic        err;
      logic [5:0]  grp_lo;
      logic [6:0]  grp_hi;
      logic        pol_lo;
      logic        pol_hi;
      logic [9:0]  column;
      logic [31:0] rel_time;
   } job_type;

endpackage

`default_nettype wire

>>> rtl/event_sensor_word_decoder.sv
// Path: the job of a word is held in the job register, and its results go from
// there into the result register. Throughput: one word per cycle while each word
// gives at most one result; a word with several results holds the input until
// its last result is emitted, and a stalled result side holds the input as well.
// Reset (synchronous) clears the timing state, the column and the sync flag.
// ----------------------------------------------------------------------------
// event_sensor_word_decoder: event sensor word decoder, top level
// Decodes sensor words into pixel events and timestamp order errors.
// ----------------------------------------------------------------------------
`default_nettype none

module event_sensor_word_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_word,
   input  wire logic        req_settle_elapsed,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic [9:0]       rsp_pos_x,
   output logic [9:0]       rsp_pos_y,
   output logic             rsp_on_polarity,
   output logic [31:0]      rsp_rel_time,
   output logic             rsp_last
);
   import esw_pkg::*;

   job_type job;
   logic    can_load;
   logic    fire;

   assign req_ready = can_load;
   assign fire      = req_valid && can_load;

   esw_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .word           (req_word),
      .settle_elapsed (req_settle_elapsed),
      .job            (job)
   );

   esw_expand u_expand (
      .clock           (clock),
      .reset           (reset),
      .load            (fire),
      .job             (job),
      .can_load        (can_load),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_on_polarity (rsp_on_polarity),
      .rsp_rel_time    (rsp_rel_time),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

>>> rtl/esw_decode.sv
// ----------------------------------------------------------------------------
// esw_decode: word decoder and timing state
// Decodes one sensor word per beat, updates column, reference time, frame
// time and sync state, and forms the job for the event expander.
// ----------------------------------------------------------------------------
`default_nettype none

module esw_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire logic [31:0]       word,
   input  wire logic              settle_elapsed,
   output esw_pkg::job_type       job
);
   import esw_pkg::*;

   logic [9:0]  column_ff,      column_in;
   logic [31:0] ref_time_ff,    ref_time_in;
   logic [31:0] frame_time_ff,  frame_time_in;
   logic [31:0] sync_offset_ff, sync_offset_in;
   logic [31:0] prev_frame_ff,  prev_frame_in;
   logic        synced_ff,      synced_in;

   logic [7:0]  b0, b1, b2, b3;
   logic [7:0]  header;
   logic [31:0] new_frame;
   logic        backward;
   logic [31:0] ref_value;

   assign b0 = word[31:24];
   assign b1 = word[23:16];
   assign b2 = word[15:8];
   assign b3 = word[7:0];
   assign header = b0 & HDR_MASK;

   assign new_frame = ref_time_ff + {22'd0, b1[4:0], b2[7:3]};
   assign backward  = new_frame < prev_frame_ff;
   assign ref_value = 32'({10'd0, b1[5:0], b2, b3} * {22'd0, REF_SCALE});

   always_comb begin
      column_in      = column_ff;
      ref_time_in    = ref_time_ff;
      frame_time_in  = frame_time_ff;
      sync_offset_in = sync_offset_ff;
      prev_frame_in  = prev_frame_ff;
      synced_in      = synced_ff;

      job          = '0;
      job.grp_lo   = b1[7:2];
      job.grp_hi   = {1'b0, b1[7:2]} + {2'b00, b0[6:2]};
      job.pol_lo   = b1[0];
      job.pol_hi   = b1[1];
      job.column   = column_ff;
      job.rel_time = frame_time_ff - sync_offset_ff;

      if (b0[7]) begin
         // Group word: events only once the time base is synced.
         if (synced_ff) begin
            job.mask = {b2, b3};
         end
      end else begin
         unique case (header)
            HDR_COLUMN: begin
               column_in = {b2[1:0], b3};
               if (b1[5]) begin
                  frame_time_in = new_frame;
                  prev_frame_in = new_frame;
                  // A backward step rebases; a first sync needs the settle time.
                  if (backward || (!synced_ff && settle_elapsed)) begin
                     sync_offset_in = new_frame;
                     synced_in      = 1'b1;
                  end
                  job.err = backward && synced_ff;
               end
            end
            HDR_REF: begin
               ref_time_in = ref_value;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff      <= '0;
         ref_time_ff    <= '0;
         frame_time_ff  <= '0;
         sync_offset_ff <= '0;
         prev_frame_ff  <= '0;
         synced_ff      <= 1'b0;
      end else if (fire) begin
         column_ff      <= column_in;
         ref_time_ff    <= ref_time_in;
         frame_time_ff  <= frame_time_in;
         sync_offset_ff <= sync_offset_in;
         prev_frame_ff  <= prev_frame_in;
         synced_ff      <= synced_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/esw_expand.sv
// ----------------------------------------------------------------------------
// esw_expand: event expander and result register
// Holds the job of the last word and walks its row masks, lowest bit first,
// or gives its order error, one result per cycle into the result register while the result side does not stall.
// ----------------------------------------------------------------------------
`default_nettype none

module esw_expand (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire esw_pkg::job_type  job,
   output logic                   can_load,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_kind,
   output logic [9:0]             rsp_pos_x,
   output logic [9:0]             rsp_pos_y,
   output logic                   rsp_on_polarity,
   output logic [31:0]            rsp_rel_time,
   output logic                   rsp_last
);
   import esw_pkg::*;

   job_type     job_ff, job_in;
   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic [9:0]  x_ff, x_in;
   logic [9:0]  y_ff, y_in;
   logic        pol_ff, pol_in;
   logic [31:0] time_ff, time_in;
   logic        last_ff, last_in;

   logic        busy;
   logic        out_free;
   logic        emit;
   logic [3:0]  idx;
   logic [15:0] rest;
   logic        final_beat;

   assign busy     = (|job_ff.mask) || job_ff.err;
   assign out_free = !valid_ff || rsp_ready;
   assign emit     = busy && out_free;

   // Lowest set bit of the pending mask.
   always_comb begin
      idx = '0;
      for (int i = 15; i >= 0; i--) begin
         if (job_ff.mask[i]) begin
            idx = 4'(i);
         end
      end
   end

   assign rest       = job_ff.mask & (job_ff.mask - 16'd1);
   assign final_beat = job_ff.err || (rest == '0);
   assign can_load   = !busy || (out_free && final_beat);

   always_comb begin
      job_in = job_ff;
      if (load) begin
         job_in = job;
      end else if (emit) begin
         job_in.mask = rest;
         job_in.err  = 1'b0;
      end

      valid_in = valid_ff;
      kind_in  = kind_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      pol_in   = pol_ff;
      time_in  = time_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         last_in  = final_beat;
         if (job_ff.err) begin
            kind_in = KIND_ERROR;
            x_in    = '0;
            y_in    = '0;
            pol_in  = 1'b0;
            time_in = '0;
         end else begin
            kind_in = KIND_PIXEL;
            x_in    = job_ff.column;
            time_in = job_ff.rel_time;
            if (idx[3]) begin
               y_in   = {job_ff.grp_hi, idx[2:0]};
               pol_in = job_ff.pol_hi;
            end else begin
               y_in   = {1'b0, job_ff.grp_lo, idx[2:0]};
               pol_in = job_ff.pol_lo;
            end
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   // Only the work flags and the result valid need a reset; the payload
   // registers are don't-care until a beat marks them valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff.mask <= '0;
         job_ff.err  <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         job_ff.mask <= job_in.mask;
         job_ff.err  <= job_in.err;
         valid_ff    <= valid_in;
      end
      job_ff.grp_lo   <= job_in.grp_lo;
      job_ff.grp_hi   <= job_in.grp_hi;
      job_ff.pol_lo   <= job_in.pol_lo;
      job_ff.pol_hi   <= job_in.pol_hi;
      job_ff.column   <= job_in.column;
      job_ff.rel_time <= job_in.rel_time;
      kind_ff         <= kind_in;
      x_ff            <= x_in;
      y_ff            <= y_in;
      pol_ff          <= pol_in;
      time_ff         <= time_in;
      last_ff         <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_pos_x       = x_ff;
   assign rsp_pos_y       = y_ff;
   assign rsp_on_polarity = pol_ff;
   assign rsp_rel_time    = time_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

>>> tb/tb_event_sensor_word_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_event_sensor_word_decoder: self-checking bench for the sensor word decoder
// Feeds reference, column and row group words, plus words the block ignores,
// with random gaps and result backpressure. Every accepted word runs through
// a predictor of the decoder. Each result beat is checked against the oldest
// pixel event or order error that the predictor expects.
// ----------------------------------------------------------------------------

import esw_pkg::*;

// Bit 7 of the first byte marks a row group word.
localparam logic [7:0] GROUP_BIT = 8'h80;

typedef struct packed {
   logic        kind;
   logic [9:0]  pos_x;
   logic [9:0]  pos_y;
   logic        on_polarity;
   logic [31:0] rel_time;
   logic        last;
} sensor_event_type;

class event_tracker_type;
   logic [9:0]       column;
   logic [31:0]      ref_time;
   logic [31:0]      frame_time;
   logic [31:0]      sync_offset;
   logic [31:0]      prev_frame_time;
   logic             synced;
   sensor_event_type events_due[$];
   int               mismatches;
   int               pixels_checked;
   int               order_errors_checked;
   int               timing_words;
   int               group_words;
   int               ignored_words;

   function new();
      column = '0;
      ref_time = '0;
      frame_time = '0;
      sync_offset = '0;
      prev_frame_time = '0;
      synced = 1'b0;
      mismatches = 0;
      pixels_checked = 0;
      order_errors_checked = 0;
      timing_words = 0;
      group_words = 0;
      ignored_words = 0;
   endfunction

   function int pending();
      return events_due.size();
   endfunction

   // Set bits of one row mask become pixel events, bit 0 first.
   function void queue_mask(logic [7:0] mask, int grp, logic pol);
      sensor_event_type ev;
      for (int n = 0; n < 8; n++) begin
         if (mask[n]) begin
            ev.kind = KIND_PIXEL;
            ev.pos_x = column;
            ev.pos_y = 10'(grp * 8 + n);
            ev.on_polarity = pol;
            ev.rel_time = frame_time - sync_offset;
            ev.last = 1'b0;
            events_due = {events_due, ev};
         end
      end
   endfunction

   function void note_word(logic [31:0] word, logic settle);
      logic [7:0]       b0, b1, b2, b3, hdr;
      int               queued;
      sensor_event_type ev;
      b0 = word[31:24];
      b1 = word[23:16];
      b2 = word[15:8];
      b3 = word[7:0];
      hdr = b0 & HDR_MASK;
      queued = events_due.size();
      if ((b0 & GROUP_BIT) != 0) begin
         group_words++;
         if (synced) begin
            queue_mask(b3, int'(b1[7:2]), b1[0]);
            queue_mask(b2, int'(b1[7:2]) + int'(b0[6:2]), b1[1]);
         end
      end else if (hdr == HDR_COLUMN) begin
         timing_words++;
         if (b1[5]) begin
            frame_time = ref_time + {22'd0, b1[4:0], b2[7:3]};
            // A backward step always rebases; only a synced block reports it.
            if (frame_time < prev_frame_time) begin
               sync_offset = frame_time;
               if (synced) begin
                  ev = '0;
                  ev.kind = KIND_ERROR;
                  events_due = {events_due, ev};
               end
               synced = 1'b1;
            end
            if (!synced && settle) begin
               sync_offset = frame_time;
               synced = 1'b1;
            end
            prev_frame_time = frame_time;
         end
         column = {b2[1:0], b3};
      end else if (hdr == HDR_REF) begin
         timing_words++;
         ref_time = {10'd0, b1[5:0], b2, b3} * 32'(REF_SCALE);
      end else begin
         ignored_words++;
      end
      if (events_due.size() > queued)
         events_due[events_due.size() - 1].last = 1'b1;
   endfunction

   task report(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task check_event(sensor_event_type got);
      sensor_event_type want;
      string            diff;
      if (events_due.size() == 0) begin
         report($sformatf("unexpected result beat kind=%0d x=%0d y=%0d",
                          got.kind, got.pos_x, got.pos_y));
         return;
      end
      want = events_due.pop_front();
      diff = "";
      if (got.kind !== want.kind)
         diff = {diff, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
      if (got.pos_x !== want.pos_x)
         diff = {diff, $sformatf(" pos_x %0d/%0d", got.pos_x, want.pos_x)};
      if (got.pos_y !== want.pos_y)
         diff = {diff, $sformatf(" pos_y %0d/%0d", got.pos_y, want.pos_y)};
      if (got.on_polarity !== want.on_polarity)
         diff = {diff, $sformatf(" polarity %0d/%0d", got.on_polarity, want.on_polarity)};
      if (got.rel_time !== want.rel_time)
         diff = {diff, $sformatf(" rel_time %0d/%0d", got.rel_time, want.rel_time)};
      if (got.last !== want.last)
         diff = {diff, $sformatf(" last %0d/%0d", got.last, want.last)};
      if (diff != "")
         report({"result differs (got/expected):", diff});
      if (want.kind == KIND_ERROR)
         order_errors_checked++;
      else
         pixels_checked++;
   endtask
endclass

module tb_event_sensor_word_decoder;
   localparam int CLOCK_HALF   = 10;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 400;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [31:0]       req_word = '0;
   logic              req_settle_elapsed = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_kind;
   logic [9:0]        rsp_pos_x;
   logic [9:0]        rsp_pos_y;
   logic              rsp_on_polarity;
   logic [31:0]       rsp_rel_time;
   logic              rsp_last;

   event_tracker_type tracker;
   sensor_event_type  rsp_beat;
   int                cycle_count = 0;
   int                hold_cycles = 0;
   int                stall_left = 0;
   bit                tx_idle_on = 1'b0;
   bit                rx_idle_on = 1'b0;
   logic [21:0]       ref_units = '0;
   logic [9:0]        sub_units = '0;

   event_sensor_word_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_word           (req_word),
      .req_settle_elapsed (req_settle_elapsed),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_on_polarity    (rsp_on_polarity),
      .rsp_rel_time       (rsp_rel_time),
      .rsp_last           (rsp_last)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_valid && req_ready)
         tracker.note_word(req_word, req_settle_elapsed);
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_beat.kind = rsp_kind;
         rsp_beat.pos_x = rsp_pos_x;
         rsp_beat.pos_y = rsp_pos_y;
         rsp_beat.on_polarity = rsp_on_polarity;
         rsp_beat.rel_time = rsp_rel_time;
         rsp_beat.last = rsp_last;
         tracker.check_event(rsp_beat);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
   end

   // Result side: a requested long hold-off wins, else random stall bursts.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            if (stall_left == 0 && rx_idle_on && $urandom_range(0, 4) == 0)
               stall_left = $urandom_range(1, 14);
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   function automatic logic [31:0] ref_word(logic [21:0] units);
      logic [3:0] r;
      r = 4'($urandom);
      return {HDR_REF | {6'd0, r[1:0]}, r[3:2], units};
   endfunction

   function automatic logic [31:0] col_word(logic [9:0] col, logic frame_start,
                                            logic [9:0] sub);
      logic [4:0] r;
      r = 5'($urandom);
      return {HDR_COLUMN | {6'd0, r[1:0]}, r[3:2], frame_start, sub, r[4], col};
   endfunction

   function automatic logic [31:0] group_word(logic [4:0] span, logic [5:0] grp,
                                              logic pol_hi, logic pol_lo,
                                              logic [7:0] upper, logic [7:0] lower);
      logic [1:0] r;
      r = 2'($urandom);
      return {GROUP_BIT | {1'b0, span, r}, grp, pol_hi, pol_lo, upper, lower};
   endfunction

   // Packet ID, padding and unknown headers: anything but column or reference.
   function automatic logic [31:0] ignored_word();
      logic [4:0] code;
      do
         code = 5'($urandom);
      while (code == HDR_COLUMN[6:2] || code == HDR_REF[6:2]);
      return {1'b0, code, 2'($urandom), 24'($urandom)};
   endfunction

   function automatic logic [7:0] random_mask();
      case ($urandom_range(0, 5))
         0: begin
            return 8'h00;
         end
         1: begin
            return 8'hFF;
         end
         2: begin
            return 8'h01 << $urandom_range(0, 7);
         end
         default: begin
            return 8'($urandom);
         end
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat.
   task automatic offer_word(input logic [31:0] word, input logic settle);
      int gap;
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         req_word <= $urandom;
         req_settle_elapsed <= 1'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= word;
      req_settle_elapsed <= settle;
      do
         @(posedge clock);
      while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (tracker.pending() != 0)
         @(negedge clock);
   endtask

   // Mostly well-formed frames: a reference word now and then, a column word,
   // then a few row group words. Time moves forward except for rare jumps.
   task automatic run_random(input int count, input bit allow_idle);
      int done;
      int pick;
      int groups;
      done = 0;
      while (done < count) begin
         tx_idle_on = allow_idle && $urandom_range(0, 3) != 0;
         rx_idle_on = allow_idle && $urandom_range(0, 3) != 0;
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            offer_word(ignored_word(), 1'($urandom));
            done++;
         end else if (pick < 30) begin
            if ($urandom_range(0, 4) == 0)
               ref_units = 22'($urandom);
            else
               ref_units += 22'($urandom_range(1, 40));
            offer_word(ref_word(ref_units), 1'($urandom));
            done++;
         end else begin
            if ($urandom_range(0, 6) == 0)
               sub_units = 10'($urandom);
            else
               sub_units += 10'($urandom_range(0, 30));
            offer_word(col_word(10'($urandom), $urandom_range(0, 9) < 7, sub_units),
                       $urandom_range(0, 4) != 0);
            done++;
            groups = $urandom_range(0, 4);
            repeat (groups)
               offer_word(group_word(5'($urandom), 6'($urandom), 1'($urandom),
                                     1'($urandom), random_mask(), random_mask()),
                          1'($urandom));
            done += groups;
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;

      // Before sync: group words are dropped and settle must gate the sync.
      offer_word(group_word(5'd31, 6'd63, 1'b1, 1'b1, 8'hFF, 8'hFF), 1'b1);
      offer_word(32'h0000_0000, 1'b1);
      offer_word(col_word(10'd0, 1'b1, 10'd0), 1'b0);
      offer_word(ref_word(22'h3F_FFFF), 1'b1);
      offer_word(col_word(10'd1023, 1'b1, 10'd1023), 1'b1);
      // Full masks at the highest row groups, then empty and single-bit masks.
      offer_word(group_word(5'd31, 6'd63, 1'b1, 1'b0, 8'hFF, 8'hFF), 1'b0);
      offer_word(group_word(5'd0, 6'd0, 1'b0, 1'b1, 8'h00, 8'h00), 1'b0);
      offer_word(group_word(5'd0, 6'd0, 1'b0, 1'b0, 8'h80, 8'h01), 1'b1);
      offer_word(col_word(10'd0, 1'b0, 10'd512), 1'b1);
      // Time jumps back to zero while synced: order error.
      offer_word(ref_word(22'd0), 1'b0);
      offer_word(col_word(10'd5, 1'b1, 10'd0), 1'b1);
      offer_word(group_word(5'd1, 6'd2, 1'b1, 1'b0, 8'h01, 8'h00), 1'b0);
      offer_word(32'h7FFF_FFFF, 1'b0);
      offer_word({8'h10, 24'hA5_5A_C3}, 1'b1);
      offer_word(ref_word(22'd1), 1'b1);
      offer_word(col_word(10'd7, 1'b1, 10'd1023), 1'b0);
      offer_word(group_word(5'd10, 6'd20, 1'b1, 1'b0, 8'hAA, 8'h55), 1'b1);
      // Equal frame time is not a backward step; one less is.
      offer_word(col_word(10'd9, 1'b1, 10'd1023), 1'b1);
      offer_word(col_word(10'd9, 1'b1, 10'd1022), 1'b1);
      offer_word(group_word(5'd3, 6'd33, 1'b0, 1'b1, 8'h0F, 8'hF0), 1'b0);
      ref_units = 22'd1;
      sub_units = 10'd0;

      run_random(50, 1'b1);

      // Hold results back for a long stretch while full groups keep coming.
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      hold_cycles = HOLD_CYCLES;
      repeat (12)
         offer_word(group_word(5'($urandom), 6'($urandom), 1'($urandom),
                               1'($urandom), 8'hFF, 8'hFF), 1'($urandom));
      wait_results_drained();

      run_random(60, 1'b1);
      run_random(30, 1'b0);

      wait_results_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Words accepted: %0d timing, %0d row group, %0d ignored.",
               tracker.timing_words, tracker.group_words, tracker.ignored_words);
      $display("Results checked: %0d pixel events, %0d order errors, %0d mismatches.",
               tracker.pixels_checked, tracker.order_errors_checked, tracker.mismatches);
      if (tracker.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
